>>> sv/mgcc_pkg.sv
package mgcc_pkg;

   localparam int unsigned CHAN_W = 8;
   localparam int unsigned COORD_W = 10;
   localparam int unsigned CNT_W = 21;
   localparam int unsigned CSR_IDX_W = 2;
   localparam int unsigned CSR_DATA_W = 21;
   localparam int unsigned REQ_DATA_W = 72;
   localparam int unsigned RSP_DATA_W = 128;

   localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

   localparam logic [CSR_IDX_W-1:0] CSR_MOTION_THRESHOLD = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_LABEL_ROW_GAP = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_WHITE_TRIGGER = 2'd2;

   localparam logic [CHAN_W-1:0] MOTION_THRESHOLD_RST = 8'd30;
   localparam logic [COORD_W-1:0] LABEL_ROW_GAP_RST = 10'd75;
   localparam logic [CNT_W-1:0] WHITE_TRIGGER_RST = 21'd100;

   // classification limits
   localparam logic [CHAN_W-1:0] YEL_R_MIN = 8'd96;
   localparam logic [CHAN_W-1:0] YEL_B_MAX = 8'd32;
   localparam logic [CHAN_W-1:0] RED_R_MIN = 8'd224;
   localparam logic [CHAN_W-1:0] RED_B_MAX = 8'd64;
   localparam logic [CHAN_W-1:0] RED_G_MAX = 8'd96;
   localparam logic [CHAN_W-1:0] PUR_MIN = 8'd128;
   localparam logic [CHAN_W-1:0] NEUTRAL_DIFF = 8'd20;
   localparam logic [CHAN_W-1:0] GRAY_LO = 8'd48;
   localparam logic [CHAN_W-1:0] GRAY_HI = 8'd80;
   localparam logic [CHAN_W-1:0] WHITE_MIN = 8'd175;

   typedef struct packed {
      logic yellow;
      logic red;
      logic purple;
      logic gray;
      logic white;
   } class_type;

   typedef struct packed {
      logic [CNT_W-1:0]   count_yellow;
      logic [CNT_W-1:0]   count_red;
      logic [CNT_W-1:0]   count_purple;
      logic [CNT_W-1:0]   count_gray;
      logic [CNT_W-1:0]   count_white;
      logic               label_found;
      logic [COORD_W-1:0] label_column;
      logic [COORD_W-1:0] label_row;
   } result_type;

   function automatic logic [CHAN_W-1:0] abs_diff(input logic [CHAN_W-1:0] a,
                                                  input logic [CHAN_W-1:0] b);
      abs_diff = (a > b) ? (a - b) : (b - a);
   endfunction

   function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] c);
      sat_inc = (c == CNT_MAX) ? c : (c + 1'b1);
   endfunction

endpackage

>>> sv/mgcc_classify.sv
module mgcc_classify (
   input  logic [mgcc_pkg::CHAN_W-1:0] red,
   input  logic [mgcc_pkg::CHAN_W-1:0] green,
   input  logic [mgcc_pkg::CHAN_W-1:0] blue,
   input  logic [mgcc_pkg::CHAN_W-1:0] prev_red,
   input  logic [mgcc_pkg::CHAN_W-1:0] prev_green,
   input  logic [mgcc_pkg::CHAN_W-1:0] prev_blue,
   input  logic [mgcc_pkg::CHAN_W-1:0] motion_threshold,
   output mgcc_pkg::class_type         pixel_class
);
   import mgcc_pkg::*;

   logic        still;
   logic        is_yellow;
   logic        is_red;
   logic        is_purple;
   logic        is_neutral;
   logic        is_gray;
   logic        is_white;
   logic [11:0] r3;
   logic [11:0] b3r;
   logic [11:0] g10;
   logic [11:0] r9;
   logic [11:0] g5;
   logic [11:0] g4;
   logic [11:0] g2;

   assign still = (abs_diff(red, prev_red) < motion_threshold)
                && (abs_diff(green, prev_green) < motion_threshold)
                && (abs_diff(blue, prev_blue) < motion_threshold);

   assign r3  = {4'd0, red} + {3'd0, red, 1'b0};
   assign b3r = {4'd0, blue} + {3'd0, blue, 1'b0} + {4'd0, red};
   assign g10 = {3'd0, green, 1'b0} + {1'b0, green, 3'd0};
   assign r9  = {4'd0, red} + {1'b0, red, 3'd0};
   assign g5  = {4'd0, green} + {2'd0, green, 2'd0};
   assign g4  = {2'd0, green, 2'd0};
   assign g2  = {3'd0, green, 1'b0};

   assign is_yellow = (red > YEL_R_MIN) && (r3 > b3r) && (blue < YEL_B_MAX)
                    && (g10 < r9) && (g5 > r3);
   assign is_red = (red > RED_R_MIN) && (blue < RED_B_MAX) && (green < RED_G_MAX);
   assign is_purple = (red > PUR_MIN) && (blue > PUR_MIN) && (g4 < r3)
                    && (g2 > {4'd0, red});
   assign is_neutral = (abs_diff(red, green) < NEUTRAL_DIFF)
                     && (abs_diff(red, blue) < NEUTRAL_DIFF)
                     && (abs_diff(green, blue) < NEUTRAL_DIFF);
   assign is_gray = (red > GRAY_LO) && (green > GRAY_LO) && (blue > GRAY_LO)
                  && (red < GRAY_HI) && (green < GRAY_HI) && (blue < GRAY_HI);
   assign is_white = (red > WHITE_MIN) && (green > WHITE_MIN) && (blue > WHITE_MIN);

   // first matching rule wins
   always_comb begin
      pixel_class = '0;
      if (still) begin
         priority if (is_yellow) begin
            pixel_class.yellow = 1'b1;
         end else if (is_red) begin
            pixel_class.red = 1'b1;
         end else if (is_purple) begin
            pixel_class.purple = 1'b1;
         end else if (is_neutral && is_gray) begin
            pixel_class.gray = 1'b1;
         end else if (is_neutral && is_white) begin
            pixel_class.white = 1'b1;
         end else begin
            pixel_class = '0;
         end
      end
   end

endmodule

>>> sv/mgcc_accum.sv
module mgcc_accum (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         pix_valid,
   input  mgcc_pkg::class_type          pixel_class,
   input  logic [mgcc_pkg::COORD_W-1:0] column,
   input  logic [mgcc_pkg::COORD_W-1:0] row,
   input  logic                         last_in_frame,
   input  logic [mgcc_pkg::COORD_W-1:0] label_row_gap,
   input  logic [mgcc_pkg::CNT_W-1:0]   white_trigger,
   output logic                         result_push,
   output mgcc_pkg::result_type         result
);
   import mgcc_pkg::*;

   logic [CNT_W-1:0]   yellow_ff, yellow_in;
   logic [CNT_W-1:0]   red_ff, red_in;
   logic [CNT_W-1:0]   purple_ff, purple_in;
   logic [CNT_W-1:0]   gray_ff, gray_in;
   logic [CNT_W-1:0]   white_ff, white_in;
   logic               seen_ff, seen_in;
   logic [COORD_W-1:0] lcol_ff, lcol_in;
   logic [COORD_W-1:0] lrow_ff, lrow_in;
   logic [COORD_W:0]   row_limit;
   logic               white_count_en;

   assign row_limit = {1'b0, lrow_ff} + {1'b0, label_row_gap};
   assign white_count_en = !seen_ff || ({1'b0, row} > row_limit);

   always_comb begin
      yellow_in = yellow_ff;
      red_in    = red_ff;
      purple_in = purple_ff;
      gray_in   = gray_ff;
      white_in  = white_ff;
      seen_in   = seen_ff;
      lcol_in   = lcol_ff;
      lrow_in   = lrow_ff;
      if (pix_valid) begin
         if (pixel_class.yellow) begin
            yellow_in = sat_inc(yellow_ff);
         end
         if (pixel_class.red) begin
            red_in = sat_inc(red_ff);
         end
         if (pixel_class.purple) begin
            purple_in = sat_inc(purple_ff);
         end
         if (pixel_class.gray) begin
            gray_in = sat_inc(gray_ff);
         end
         if (pixel_class.white) begin
            if (white_count_en) begin
               white_in = sat_inc(white_ff);
            end
            if (!seen_ff && (white_in > white_trigger)) begin
               seen_in = 1'b1;
               lcol_in = column;
               lrow_in = row;
            end
         end
      end
   end

   assign result_push = pix_valid && last_in_frame;

   always_comb begin
      result.count_yellow = yellow_in;
      result.count_red    = red_in;
      result.count_purple = purple_in;
      result.count_gray   = gray_in;
      result.count_white  = white_in;
      result.label_found  = seen_in;
      result.label_column = seen_in ? lcol_in : '0;
      result.label_row    = seen_in ? lrow_in : '0;
   end

   always_ff @(posedge clock) begin
      if (reset || result_push) begin
         yellow_ff <= '0;
         red_ff    <= '0;
         purple_ff <= '0;
         gray_ff   <= '0;
         white_ff  <= '0;
         seen_ff   <= 1'b0;
         lcol_ff   <= '0;
         lrow_ff   <= '0;
      end else begin
         yellow_ff <= yellow_in;
         red_ff    <= red_in;
         purple_ff <= purple_in;
         gray_ff   <= gray_in;
         white_ff  <= white_in;
         seen_ff   <= seen_in;
         lcol_ff   <= lcol_in;
         lrow_ff   <= lrow_in;
      end
   end

endmodule

>>> sv/mgcc_rsp_queue.sv
module mgcc_rsp_queue (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push,
   input  mgcc_pkg::result_type push_data,
   output logic                 pop_valid,
   input  logic                 pop_ready,
   output mgcc_pkg::result_type pop_data,
   output logic [1:0]           fill
);
   import mgcc_pkg::*;

   result_type mem_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;
   logic       pop;

   assign pop       = pop_valid && pop_ready;
   assign pop_valid = (count_ff != 2'd0);
   assign pop_data  = mem_ff[rd_ptr_ff];
   assign fill      = count_ff;

   always_comb begin
      wr_ptr_in = push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? !rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

>>> sv/motion_gated_color_class_counter.sv
// a frame's result appears once its last request has passed the input register and the result queue
// throughput: one request per cycle; the two-entry result queue holds requests
//   back only when it could overflow (full, or one result queued and another in
//   flight) and no result leaves in that cycle
// reset: synchronous, active high; clears all counts, the label position and the
//   result queue, and restores thresholds to 30, 75 and 100
module motion_gated_color_class_counter (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_tvalid,
   output logic                               req_tready,
   // red, green, blue, prev_red, prev_green, prev_blue, column, row, zero pad
   input  logic [mgcc_pkg::REQ_DATA_W-1:0]    req_tdata,
   input  logic                               req_tlast,
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   // count_yellow, count_red, count_purple, count_gray, count_white,
   // label_found, label_column, label_row, zero pad
   output logic [mgcc_pkg::RSP_DATA_W-1:0]    rsp_tdata,
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic [mgcc_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [mgcc_pkg::CSR_DATA_W-1:0]    csr_data
);
   import mgcc_pkg::*;

   logic [CHAN_W-1:0]  motion_threshold_ff;
   logic [COORD_W-1:0] label_row_gap_ff;
   logic [CNT_W-1:0]   white_trigger_ff;

   logic               pix_valid_ff;
   logic [CHAN_W-1:0]  red_ff, green_ff, blue_ff;
   logic [CHAN_W-1:0]  prev_red_ff, prev_green_ff, prev_blue_ff;
   logic [COORD_W-1:0] column_ff, row_ff;
   logic               last_ff;

   logic               req_accept;
   logic               rsp_pop;
   class_type          pixel_class;
   logic               result_push;
   result_type         result;
   result_type         rsp_result;
   logic [1:0]         fill;

   assign csr_ready  = 1'b1;
   assign req_accept = req_tvalid && req_tready;
   assign rsp_pop    = rsp_tvalid && rsp_tready;
   // room for a result from the held request and one from the incoming one
   assign req_tready = ({1'b0, fill} + {2'd0, pix_valid_ff && last_ff})
                       <= ({2'd0, rsp_pop} + 3'd1);

   always_ff @(posedge clock) begin
      if (reset) begin
         motion_threshold_ff <= MOTION_THRESHOLD_RST;
         label_row_gap_ff    <= LABEL_ROW_GAP_RST;
         white_trigger_ff    <= WHITE_TRIGGER_RST;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_MOTION_THRESHOLD: begin
               motion_threshold_ff <= csr_data[CHAN_W-1:0];
            end
            CSR_LABEL_ROW_GAP: begin
               label_row_gap_ff <= csr_data[COORD_W-1:0];
            end
            CSR_WHITE_TRIGGER: begin
               white_trigger_ff <= csr_data[CNT_W-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pix_valid_ff <= 1'b0;
      end else begin
         pix_valid_ff <= req_accept;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         red_ff        <= req_tdata[7:0];
         green_ff      <= req_tdata[15:8];
         blue_ff       <= req_tdata[23:16];
         prev_red_ff   <= req_tdata[31:24];
         prev_green_ff <= req_tdata[39:32];
         prev_blue_ff  <= req_tdata[47:40];
         column_ff     <= req_tdata[57:48];
         row_ff        <= req_tdata[67:58];
         last_ff       <= req_tlast;
      end
   end

   mgcc_classify u_classify (
      .red              (red_ff),
      .green            (green_ff),
      .blue             (blue_ff),
      .prev_red         (prev_red_ff),
      .prev_green       (prev_green_ff),
      .prev_blue        (prev_blue_ff),
      .motion_threshold (motion_threshold_ff),
      .pixel_class      (pixel_class)
   );

   mgcc_accum u_accum (
      .clock         (clock),
      .reset         (reset),
      .pix_valid     (pix_valid_ff),
      .pixel_class   (pixel_class),
      .column        (column_ff),
      .row           (row_ff),
      .last_in_frame (last_ff),
      .label_row_gap (label_row_gap_ff),
      .white_trigger (white_trigger_ff),
      .result_push   (result_push),
      .result        (result)
   );

   mgcc_rsp_queue u_rsp_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (result_push),
      .push_data (result),
      .pop_valid (rsp_tvalid),
      .pop_ready (rsp_tready),
      .pop_data  (rsp_result),
      .fill      (fill)
   );

   assign rsp_tdata = {2'd0,
                       rsp_result.label_row,
                       rsp_result.label_column,
                       rsp_result.label_found,
                       rsp_result.count_white,
                       rsp_result.count_gray,
                       rsp_result.count_purple,
                       rsp_result.count_red,
                       rsp_result.count_yellow};

endmodule
